// File: hdl/rfw_pkg.sv
// Shared types and constants for the rectangle fill writer.
// Holds the request and response item structs, the start decode struct and the codes.
// No dependencies.
package rfw_pkg;

  localparam int ADDR_W = 17;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_BUSY   = 2'd3;

  typedef struct packed {
    logic               mode;
    logic               page;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [7:0]         fill_color;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] byte_address;
    logic [31:0]       write_data;
    logic              is_word;
    logic              last;
  } rsp_t;

  // Outcome of checking a start item against the screen.
  typedef struct packed {
    logic              reject;
    logic              empty;
    logic [ADDR_W-1:0] base_address;
  } start_info_t;

endpackage

// File: hdl/rfw_start_check.sv
// Decodes a start item: off-screen check, empty check and first byte address.
// Depends on rfw_pkg.
module rfw_start_check #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int PAGE_BYTES    = 65536
) (
  input  rfw_pkg::req_t        req,
  output rfw_pkg::start_info_t info
);

  localparam int ADDR_W = rfw_pkg::ADDR_W;
  localparam int PX_W   = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam logic signed [16:0] SW_S    = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] SH_S    = 17'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] SW_C     = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] PAGE_OFS = ADDR_W'(PAGE_BYTES % (1 << ADDR_W));

  logic signed [16:0] right_edge;
  logic signed [16:0] bottom_edge;
  logic [ROW_W-1:0]   row_idx;
  logic [PX_W-1:0]    col_idx;
  logic [ADDR_W-1:0]  row_ofs;
  logic [ADDR_W-1:0]  page_ofs;

  // Exact signed sums; one extra bit keeps them from overflowing.
  assign right_edge  = 17'(req.left_x) + 17'(req.rect_width);
  assign bottom_edge = 17'(req.top_y) + 17'(req.rect_height);

  assign info.reject = req.left_x[15] || req.top_y[15] ||
                       (right_edge > SW_S) || (bottom_edge > SH_S);
  assign info.empty  = req.rect_width[15] || (req.rect_width == 16'sd0) ||
                       req.rect_height[15] || (req.rect_height == 16'sd0);

  // The address only matters when the rectangle passed the check, and then the
  // corner lies on screen, so the narrow slices hold the whole coordinate.
  assign row_idx  = req.top_y[ROW_W-1:0];
  assign col_idx  = req.left_x[PX_W-1:0];
  assign row_ofs  = ADDR_W'(ADDR_W'(row_idx) * SW_C);
  assign page_ofs = req.page ? PAGE_OFS : '0;
  assign info.base_address = page_ofs + row_ofs + ADDR_W'(col_idx);

endmodule

// File: hdl/rfw_walker.sv
// Rectangle walk state: holds the cursor and counters and forms the result of each item.
// Depends on rfw_pkg and the start decode from rfw_start_check.
module rfw_walker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  rfw_pkg::req_t        req,
  input  rfw_pkg::start_info_t info,
  output logic                 has_result,
  output rfw_pkg::rsp_t        result
);

  localparam int ADDR_W = rfw_pkg::ADDR_W;
  localparam int PX_W   = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam logic [ADDR_W-1:0] SW_C     = ADDR_W'(SCREEN_WIDTH);
  localparam logic [PX_W-1:0]   PX_WORD  = PX_W'(4);
  localparam logic [PX_W-1:0]   PX_BYTE  = PX_W'(1);
  localparam logic [ROW_W-1:0]  ROW_ONE  = ROW_W'(1);

  logic              busy, busy_next;
  logic [ADDR_W-1:0] cursor_address, cursor_address_next;
  logic [ADDR_W-1:0] row_start_address, row_start_address_next;
  logic [PX_W-1:0]   pixels_left_in_row, pixels_left_in_row_next;
  logic [ROW_W-1:0]  rows_left, rows_left_next;
  logic [PX_W-1:0]   row_width, row_width_next;
  logic [7:0]        held_color, held_color_next;

  logic              is_start;
  logic              start_ok;
  logic              word;
  logic [PX_W-1:0]   px_after;
  logic              row_done;
  logic              rect_done;

  assign is_start  = (req.mode == rfw_pkg::MODE_START);
  assign start_ok  = is_start && !busy && !info.reject && !info.empty;
  assign word      = (cursor_address[1:0] == 2'b00) && (pixels_left_in_row >= PX_WORD);
  assign px_after  = pixels_left_in_row - (word ? PX_WORD : PX_BYTE);
  assign row_done  = (px_after == '0);
  assign rect_done = row_done && (rows_left == ROW_ONE);

  always_comb begin
    has_result = is_start ? !start_ok : busy;
    result     = '0;
    result.last = 1'b1;
    if (is_start) begin
      if (busy) begin
        result.kind = rfw_pkg::KIND_BUSY;
      end else if (info.reject) begin
        result.kind = rfw_pkg::KIND_REJECT;
      end else begin
        result.kind = rfw_pkg::KIND_EMPTY;
      end
    end else begin
      result.kind         = rfw_pkg::KIND_WRITE;
      result.byte_address = cursor_address;
      result.write_data   = {4{held_color}};
      result.is_word      = word;
      result.last         = rect_done;
    end
  end

  always_comb begin
    busy_next               = busy;
    cursor_address_next     = cursor_address;
    row_start_address_next  = row_start_address;
    pixels_left_in_row_next = pixels_left_in_row;
    rows_left_next          = rows_left;
    row_width_next          = row_width;
    held_color_next         = held_color;
    if (fire && start_ok) begin
      busy_next               = 1'b1;
      cursor_address_next     = info.base_address;
      row_start_address_next  = info.base_address;
      row_width_next          = req.rect_width[PX_W-1:0];
      pixels_left_in_row_next = req.rect_width[PX_W-1:0];
      rows_left_next          = req.rect_height[ROW_W-1:0];
      held_color_next         = req.fill_color;
    end else if (fire && !is_start && busy) begin
      cursor_address_next     = cursor_address + (word ? ADDR_W'(4) : ADDR_W'(1));
      pixels_left_in_row_next = px_after;
      if (row_done) begin
        rows_left_next = rows_left - ROW_ONE;
        if (rect_done) begin
          busy_next = 1'b0;
        end else begin
          row_start_address_next  = row_start_address + SW_C;
          cursor_address_next     = row_start_address + SW_C;
          pixels_left_in_row_next = row_width;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b0;
      cursor_address     <= '0;
      row_start_address  <= '0;
      pixels_left_in_row <= '0;
      rows_left          <= '0;
      row_width          <= '0;
      held_color         <= '0;
    end else begin
      busy               <= busy_next;
      cursor_address     <= cursor_address_next;
      row_start_address  <= row_start_address_next;
      pixels_left_in_row <= pixels_left_in_row_next;
      rows_left          <= rows_left_next;
      row_width          <= row_width_next;
      held_color         <= held_color_next;
    end
  end

`ifndef ASSERT_OFF
  a_busy_counts: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pixels_left_in_row != '0) && (rows_left != '0) && (row_width != '0))
    else $error("walk active with an exhausted counter");

  a_px_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pixels_left_in_row <= row_width))
    else $error("pixels left exceed the row width");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    (has_result && result.kind == rfw_pkg::KIND_WRITE && result.is_word) |->
      (result.byte_address[1:0] == 2'b00))
    else $error("word write at an unaligned address");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && has_result && result.kind == rfw_pkg::KIND_WRITE && result.last) |=> !busy)
    else $error("walk still active after its last write");
`endif

endmodule

// File: hdl/rect_fill_writer_core.sv
// Top level of the rectangle fill writer: input register, start decode, walk state and
// result register. Depends on rfw_pkg, rfw_start_check and rfw_walker.
//
// Usage. The req channel takes items of type rfw_pkg::req_t under valid/ready. A start
// item (mode start) names page, corner, size and colour; a rectangle that leaves the
// screen is answered with a reject result, an empty one with an empty result, and a
// start that arrives while a rectangle is being filled is answered with a busy result
// and otherwise ignored. An accepted start gives no result. Each tick item then gives
// one framebuffer write on the rsp channel (rfw_pkg::rsp_t): a word write when the
// address is word aligned and four or more pixels remain in the row, else a byte write.
// The final write of a rectangle, and every non-write result, carries last. A tick
// while idle gives nothing.
//
// Timing. An accepted item sits in the input register, where the check and the walk step
// are worked out, and its result is then captured in the result register. One item is
// taken every cycle while results are drained. When the receiver stalls, the result
// register holds its item and the input register holds the next one that produces a
// result; req_ready then drops.
// Reset (rst, synchronous) empties both registers and returns the walker to idle.
module rect_fill_writer_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int PAGE_BYTES    = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rfw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rfw_pkg::rsp_t rsp
);

  // Input register.
  logic          hold_valid;
  rfw_pkg::req_t hold_req;

  // Work on the held item.
  rfw_pkg::start_info_t info;
  logic                 has_result;
  rfw_pkg::rsp_t        result;
  logic                 out_free;
  logic                 fire;

  // The held item may leave when it yields no result, or when the result register
  // is empty or being emptied in this cycle.
  assign out_free  = !rsp_valid || rsp_ready;
  assign fire      = hold_valid && (!has_result || out_free);
  assign req_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  // Payload carries no reset; it is only looked at when hold_valid is set.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_req <= req;
    end
  end

  rfw_start_check #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .PAGE_BYTES    (PAGE_BYTES)
  ) u_check (
    .req  (hold_req),
    .info (info)
  );

  rfw_walker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (hold_req),
    .info       (info),
    .has_result (has_result),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire && has_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      rsp <= result;
    end
  end

endmodule

// File: tb/rect_fill_writer_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rect_fill_writer_core: a directed table, then random rectangles.
// Depends on rfw_pkg and rect_fill_writer_core; predicts every result on its own.
module rect_fill_writer_core_test;

  localparam int SCREEN_W      = 320;
  localparam int SCREEN_H      = 200;
  localparam int FB_PAGE_BYTES = 65536;

  // Outcome column of the directed table: a kind code, or one of these two.
  localparam int OUTCOME_NONE    = -1;
  localparam int OUTCOME_PREDICT = -2;

  localparam int ITEM_TARGET    = 400;
  localparam int CALM_FROM      = 340;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    rfw_pkg::req_t item;
    int            reps;
    int            outcome;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  rfw_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  rfw_pkg::rsp_t rsp;

  // Our own copy of the fill walker, at reset values.
  logic        walk_busy        = 1'b0;
  logic [16:0] walk_cursor      = '0;
  logic [16:0] walk_row_base    = '0;
  logic [8:0]  walk_pixels_left = '0;
  logic [7:0]  walk_rows_left   = '0;
  logic [8:0]  walk_row_width   = '0;
  logic [7:0]  walk_colour      = '0;

  rfw_pkg::rsp_t fill_results_due[$];
  plan_row_t     directed_plan[$];

  int errors       = 0;
  int items_in     = 0;
  int results_out  = 0;
  int word_writes  = 0;
  int byte_writes  = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int idle_cycles  = 0;

  bit sender_gaps  = 1'b0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  rect_fill_writer_core #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .PAGE_BYTES   (FB_PAGE_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Works out what one accepted item gives, and advances the walker copy.
  function automatic bit next_fill_result(input rfw_pkg::req_t item, output rfw_pkg::rsp_t res);
    int lx;
    int ty;
    int w;
    int h;
    bit word;
    lx = $signed(item.left_x);
    ty = $signed(item.top_y);
    w  = $signed(item.rect_width);
    h  = $signed(item.rect_height);
    res = '0;
    res.last = 1'b1;
    if (item.mode == rfw_pkg::MODE_START) begin
      if (walk_busy) begin
        res.kind = rfw_pkg::KIND_BUSY;
        return 1'b1;
      end
      // The sums are taken at full width, so a huge size cannot wrap back on screen.
      if (lx < 0 || ty < 0 || lx + w > SCREEN_W || ty + h > SCREEN_H) begin
        res.kind = rfw_pkg::KIND_REJECT;
        return 1'b1;
      end
      if (w <= 0 || h <= 0) begin
        res.kind = rfw_pkg::KIND_EMPTY;
        return 1'b1;
      end
      walk_row_base    = 17'(int'(item.page) * FB_PAGE_BYTES + ty * SCREEN_W + lx);
      walk_cursor      = walk_row_base;
      walk_row_width   = 9'(w);
      walk_pixels_left = 9'(w);
      walk_rows_left   = 8'(h);
      walk_colour      = item.fill_color;
      walk_busy        = 1'b1;
      return 1'b0;
    end
    if (!walk_busy) return 1'b0;
    word = (walk_cursor[1:0] == 2'b00) && (walk_pixels_left >= 9'd4);
    res.kind         = rfw_pkg::KIND_WRITE;
    res.byte_address = walk_cursor;
    res.write_data   = {4{walk_colour}};
    res.is_word      = word;
    res.last         = 1'b0;
    walk_cursor      = walk_cursor + (word ? 17'd4 : 17'd1);
    walk_pixels_left = walk_pixels_left - (word ? 9'd4 : 9'd1);
    if (walk_pixels_left == 9'd0) begin
      walk_rows_left = walk_rows_left - 8'd1;
      if (walk_rows_left == 8'd0) begin
        walk_busy = 1'b0;
        res.last  = 1'b1;
      end else begin
        walk_row_base    = walk_row_base + 17'(SCREEN_W);
        walk_cursor      = walk_row_base;
        walk_pixels_left = walk_row_width;
      end
    end
    return 1'b1;
  endfunction

  function automatic rfw_pkg::req_t random_req();
    rfw_pkg::req_t item;
    item.mode        = 1'($urandom);
    item.page        = 1'($urandom);
    item.left_x      = 16'($urandom);
    item.top_y       = 16'($urandom);
    item.rect_width  = 16'($urandom);
    item.rect_height = 16'($urandom);
    item.fill_color  = 8'($urandom);
    return item;
  endfunction

  function automatic void plan_row(input logic mode, input logic page, input int lx, input int ty,
                                   input int w, input int h, input int colour, input int reps,
                                   input int outcome);
    plan_row_t row;
    row.item.mode        = mode;
    row.item.page        = page;
    row.item.left_x      = 16'(lx);
    row.item.top_y       = 16'(ty);
    row.item.rect_width  = 16'(w);
    row.item.rect_height = 16'(h);
    row.item.fill_color  = 8'(colour);
    row.reps             = reps;
    row.outcome          = outcome;
    directed_plan.push_back(row);
  endfunction

  function automatic void check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endfunction

  // Offers one item and holds it until taken. Valid is left high so that the next call
  // can replace the payload at the same edge; whoever lets time pass lowers it first.
  task automatic send_item(input rfw_pkg::req_t item, input int outcome);
    rfw_pkg::rsp_t res;
    rfw_pkg::rsp_t typed;
    bit            gives;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    gives = next_fill_result(item, res);
    if (outcome == OUTCOME_PREDICT) begin
      if (gives) fill_results_due.push_back(res);
    end else if (outcome != OUTCOME_NONE) begin
      typed      = '0;
      typed.kind = 2'(outcome);
      typed.last = 1'b1;
      fill_results_due.push_back(typed);
    end
    items_in++;
    if (items_in % 40 == 0) sender_gaps = 1'($urandom);
    if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the final stretch.
  initial begin : receiver
    int  cycles;
    bit  stalls;
    rsp_ready = 1'b0;
    cycles    = 0;
    stalls    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        cycles++;
        if (cycles % 50 == 0) stalls = 1'($urandom);
        if (hold_request) begin
          rsp_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
          rsp_ready <= 1'b1;
        end else if (!calm && stalls && $urandom_range(0, 7) == 0) begin
          rsp_ready <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
          rsp_ready <= 1'b1;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // Every result taken is matched against the oldest one still due.
  always @(posedge clk) begin : result_check
    rfw_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_out++;
      if (fill_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: kind %0d, address 0x%0h, data 0x%0h",
                 $time, rsp.kind, rsp.byte_address, rsp.write_data);
      end else begin
        want = fill_results_due.pop_front();
        check_field("kind", want.kind, rsp.kind);
        check_field("byte_address", want.byte_address, rsp.byte_address);
        check_field("write_data", want.write_data, rsp.write_data);
        check_field("is_word", want.is_word, rsp.is_word);
        check_field("last", want.last, rsp.last);
        kind_seen[rsp.kind]++;
        if (rsp.kind == rfw_pkg::KIND_WRITE) begin
          if (rsp.is_word) word_writes++;
          else byte_writes++;
        end
      end
    end
  end

  // The run ends if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still due",
                 $time, idle_cycles, fill_results_due.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rfw_pkg::req_t item;
    int            sel;
    int            lx;
    int            ty;
    int            w;
    int            h;
    bit            held;
    bit            paused;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    held      = 1'b0;
    paused    = 1'b0;

    // Directed table: off-screen and empty cases, the far corner on page one, and a
    // start that lands while a rectangle is being filled.
    plan_row(rfw_pkg::MODE_TICK,  1'b0, 0, 0, 0, 0, 8'h00, 1, OUTCOME_NONE);
    plan_row(rfw_pkg::MODE_START, 1'b0, -1, 0, 1, 1, 8'h11, 1, int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, -32768, 1, 1, 8'h22, 1, int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b1, 32767, 0, 1, 1, 8'h33, 1, int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, 0, 321, 1, 8'h44, 1, int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, 0, 1, 201, 8'h55, 1, int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b1, 0, 0, 32767, 32767, 8'h66, 1,
             int'(rfw_pkg::KIND_REJECT));
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, 0, 0, 5, 8'h77, 1, int'(rfw_pkg::KIND_EMPTY));
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, 0, -32768, -32768, 8'h88, 1,
             int'(rfw_pkg::KIND_EMPTY));
    plan_row(rfw_pkg::MODE_START, 1'b1, 320, 200, 0, 0, 8'h99, 1, int'(rfw_pkg::KIND_EMPTY));
    plan_row(rfw_pkg::MODE_START, 1'b0, 5, 0, 3, -1, 8'hAA, 1, int'(rfw_pkg::KIND_EMPTY));
    plan_row(rfw_pkg::MODE_START, 1'b1, 319, 199, 1, 1, 8'hFF, 1, OUTCOME_PREDICT);
    plan_row(rfw_pkg::MODE_START, 1'b0, 0, 0, 4, 4, 8'h12, 1, int'(rfw_pkg::KIND_BUSY));
    plan_row(rfw_pkg::MODE_TICK,  1'b0, 0, 0, 0, 0, 8'h00, 1, OUTCOME_PREDICT);
    plan_row(rfw_pkg::MODE_TICK,  1'b1, -1, -1, -1, -1, 8'hFF, 1, OUTCOME_NONE);
    // Seven pixels from column two: two bytes, one word and a byte on each row.
    plan_row(rfw_pkg::MODE_START, 1'b0, 2, 3, 7, 2, 8'hA5, 1, OUTCOME_PREDICT);
    plan_row(rfw_pkg::MODE_TICK,  1'b0, 0, 0, 0, 0, 8'h00, 3, OUTCOME_PREDICT);
    plan_row(rfw_pkg::MODE_START, 1'b1, 10, 10, 2, 2, 8'h5A, 1, int'(rfw_pkg::KIND_BUSY));
    plan_row(rfw_pkg::MODE_TICK,  1'b1, 123, 45, 6, 7, 8'h3C, 5, OUTCOME_PREDICT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      repeat (directed_plan[i].reps) send_item(directed_plan[i].item, directed_plan[i].outcome);
    end

    // Random part: mostly well-formed rectangles walked to the end with random tick
    // payloads and the odd start while busy, plus noise starts and ticks.
    while (items_in < ITEM_TARGET) begin
      calm = (items_in >= CALM_FROM);
      if (!held && items_in >= 150) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      if (!paused && items_in >= 250) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        do @(posedge clk); while (fill_results_due.size() != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        send_item(random_req(), OUTCOME_PREDICT);
      end else begin
        item      = random_req();
        item.mode = rfw_pkg::MODE_START;
        if (sel < 12) begin
          // A whole screen row.
          lx = 0;
          w  = SCREEN_W;
          ty = $urandom_range(0, SCREEN_H - 1);
          h  = 1;
        end else if (sel < 14) begin
          // A tall narrow column, down to the bottom edge at most.
          w  = $urandom_range(1, 4);
          lx = $urandom_range(0, SCREEN_W - w);
          h  = $urandom_range(16, 32);
          ty = $urandom_range(0, SCREEN_H - h);
        end else if (sel < 22) begin
          // Right at the screen edge: either one past it, or flush with no rows.
          lx = $urandom_range(0, SCREEN_W);
          ty = $urandom_range(0, SCREEN_H);
          w  = SCREEN_W - lx + int'($urandom_range(0, 1));
          h  = 0 - int'($urandom_range(0, 3));
        end else begin
          w  = $urandom_range(1, 12);
          h  = $urandom_range(1, 3);
          lx = $urandom_range(0, SCREEN_W - w);
          ty = $urandom_range(0, SCREEN_H - h);
        end
        item.left_x      = 16'(lx);
        item.top_y       = 16'(ty);
        item.rect_width  = 16'(w);
        item.rect_height = 16'(h);
        send_item(item, OUTCOME_PREDICT);
        while (walk_busy) begin
          item      = random_req();
          item.mode = ($urandom_range(0, 15) == 0) ? rfw_pkg::MODE_START : rfw_pkg::MODE_TICK;
          send_item(item, OUTCOME_PREDICT);
        end
      end
    end

    req_valid <= 1'b0;
    while (fill_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d items in and %0d results out: %0d word and %0d byte writes,",
             items_in, results_out, word_writes, byte_writes);
    $display("%0d off-screen rejects, %0d empty rectangles and %0d starts dropped while busy.",
             kind_seen[rfw_pkg::KIND_REJECT], kind_seen[rfw_pkg::KIND_EMPTY],
             kind_seen[rfw_pkg::KIND_BUSY]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
